[hdl/assert_macros.svh]
// Assertion helpers, clocked on i_clk and quiet while i_rst_n is low.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication.
`define RTC_ASSERT_IMP(name, ante, cons, msg) \
    name: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication.
`define RTC_ASSERT_NXT(name, ante, cons, msg) \
    name: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

[hdl/rtc_pkg.sv]
package rtc_pkg;

    localparam int unsigned BINS_DEF          = 256;
    localparam int unsigned STEPS_DEF         = 1000;
    localparam int unsigned OPACITY_REF_STEPS = 500;

    localparam logic [31:0] Q16_ONE   = 32'd65536;
    localparam logic [63:0] Q31_ONE   = 64'd2147483648;
    localparam logic [15:0] RECIP_255 = 16'd32897;

    localparam logic CMD_LOAD = 1'b1;

    localparam int unsigned APB_AW = 4;

    localparam logic [1:0] REG_RANGE_MIN = 2'd0;
    localparam logic [1:0] REG_RANGE_MAX = 2'd1;
    localparam logic [1:0] REG_BIN_SCALE = 2'd2;

    localparam logic [31:0] RANGE_MIN_RST = 32'd655360;
    localparam logic [31:0] RANGE_MAX_RST = 32'd983040;
    localparam logic [31:0] BIN_SCALE_RST = 32'd3355443;

    typedef struct packed {
        logic [31:0] range_min;
        logic [31:0] range_max;
        logic [31:0] bin_scale;
    } t_cfg;

    typedef logic [255:0][16:0] t_op_rom;

    function automatic int unsigned gcd(input int unsigned a_in, input int unsigned b_in);
        int unsigned a;
        int unsigned b;
        a = a_in;
        b = b_in;
        while (a != b) begin
            if (a > b) begin
                a = a - b;
            end else begin
                b = b - a;
            end
        end
        return a;
    endfunction

    function automatic logic [63:0] mul_q31(input logic [63:0] a, input logic [63:0] b);
        return (a * b) >> 31;
    endfunction

    function automatic logic [63:0] pow_q31(input logic [63:0] base_in, input int unsigned e_in);
        logic [63:0] r;
        logic [63:0] b;
        int unsigned e;
        r = Q31_ONE;
        b = base_in;
        e = e_in;
        while (e != 0) begin
            if (e[0]) begin
                r = mul_q31(r, b);
            end
            b = mul_q31(b, b);
            e = e >> 1;
        end
        return r;
    endfunction

    // Step-corrected opacity: 1 - (1 - byte/255)^(p/q), Q1.16.
    function automatic t_op_rom build_op_rom(input int unsigned p, input int unsigned q);
        t_op_rom     rom;
        logic [63:0] x;
        logic [63:0] big;
        logic [31:0] lo;
        logic [31:0] hi;
        logic [31:0] mid;
        for (int k = 0; k < 256; k++) begin
            x   = (64'(255 - k) << 31) / 64'd255;
            big = pow_q31(x, p);
            lo  = 32'd0;
            hi  = Q16_ONE;
            if (big != 64'd0) begin
                while (lo < hi) begin
                    mid = (lo + hi + 32'd1) >> 1;
                    if (pow_q31(64'(mid) << 15, q) <= big) begin
                        lo = mid;
                    end else begin
                        hi = mid - 32'd1;
                    end
                end
            end
            rom[k] = 17'(Q16_ONE - lo);
        end
        return rom;
    endfunction

endpackage

[hdl/rtc_in_if.sv]
interface rtc_in_if;
    logic              valid;
    logic              ready;
    logic              cmd;
    logic signed [31:0] sample_value;
    logic              last_sample;
    logic [7:0]        entry_index;
    logic [7:0]        entry_red;
    logic [7:0]        entry_green;
    logic [7:0]        entry_blue;
    logic [7:0]        entry_opacity;

    modport source (
        output valid, cmd, sample_value, last_sample, entry_index,
               entry_red, entry_green, entry_blue, entry_opacity,
        input  ready
    );

    modport sink (
        input  valid, cmd, sample_value, last_sample, entry_index,
               entry_red, entry_green, entry_blue, entry_opacity,
        output ready
    );
endinterface

[hdl/rtc_out_if.sv]
interface rtc_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] pixel_red;
    logic [7:0] pixel_green;
    logic [7:0] pixel_blue;

    modport source (
        output valid, pixel_red, pixel_green, pixel_blue,
        input  ready
    );

    modport sink (
        input  valid, pixel_red, pixel_green, pixel_blue,
        output ready
    );
endinterface

[hdl/rtc_cfg_regs.sv]
module rtc_cfg_regs (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [rtc_pkg::APB_AW-1:0]  paddr,
    input  logic [31:0]                 pwdata,
    output logic [31:0]                 prdata,
    output logic                        pready,
    output rtc_pkg::t_cfg               o_cfg
);

    rtc_pkg::t_cfg r_cfg;
    logic          wr_en;

    assign pready = 1'b1;
    assign wr_en  = psel && penable && pwrite;
    assign o_cfg  = r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.range_min <= rtc_pkg::RANGE_MIN_RST;
            r_cfg.range_max <= rtc_pkg::RANGE_MAX_RST;
            r_cfg.bin_scale <= rtc_pkg::BIN_SCALE_RST;
        end else if (wr_en) begin
            case (paddr[3:2])
                rtc_pkg::REG_RANGE_MIN: r_cfg.range_min <= pwdata;
                rtc_pkg::REG_RANGE_MAX: r_cfg.range_max <= pwdata;
                rtc_pkg::REG_BIN_SCALE: r_cfg.bin_scale <= pwdata;
                default: ;
            endcase
        end
    end

    always_comb begin
        case (paddr[3:2])
            rtc_pkg::REG_RANGE_MIN: prdata = r_cfg.range_min;
            rtc_pkg::REG_RANGE_MAX: prdata = r_cfg.range_max;
            rtc_pkg::REG_BIN_SCALE: prdata = r_cfg.bin_scale;
            default:                prdata = 32'd0;
        endcase
    end

endmodule

[hdl/ray_transfer_compositing_core.sv]
// Front-to-back compositing of one ray's scalar samples through a BINS-entry transfer table.
// A load word (cmd = 1) writes one table entry {opacity, blue, green, red} in its accept
// cycle, so loads stream at one word per cycle while no sample is in progress; indexes at or
// above BINS are dropped. A sample word (cmd = 0) inside [range_min, range_max] passes through
// bin multiply, table read (synchronous RAM), opacity weight multiply, color multiply,
// reciprocal divide by 255, accumulate and finish before the next word can be taken. A sample
// outside the range goes straight to finish. The sequencer handles one sample at a time because
// each weight depends on the alpha accumulated by the sample before it. The sample marked last
// loads the pixel register and clears the accumulators; the pixel waits there while further
// words are accepted, and a following last sample stalls only in its finish cycle until the
// pixel is taken. Registers on the APB port: range_min at 0x0, range_max at 0x4, bin_scale at
// 0x8. Table entries read before being loaded return undefined data.
`include "assert_macros.svh"

module ray_transfer_compositing_core #(
    parameter int unsigned BINS  = rtc_pkg::BINS_DEF,
    parameter int unsigned STEPS = rtc_pkg::STEPS_DEF
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    rtc_in_if.sink                      i_smp,
    rtc_out_if.source                   o_pix,
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [rtc_pkg::APB_AW-1:0]  paddr,
    input  logic [31:0]                 pwdata,
    output logic [31:0]                 prdata,
    output logic                        pready
);

    localparam int unsigned AW     = $clog2(BINS);
    localparam int unsigned OP_GCD = rtc_pkg::gcd(rtc_pkg::OPACITY_REF_STEPS, STEPS);
    localparam int unsigned OP_P   = rtc_pkg::OPACITY_REF_STEPS / OP_GCD;
    localparam int unsigned OP_Q   = STEPS / OP_GCD;
    localparam rtc_pkg::t_op_rom OP_ROM = rtc_pkg::build_op_rom(OP_P, OP_Q);

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_MUL  = 3'd1;
    localparam logic [2:0] S_RD   = 3'd2;
    localparam logic [2:0] S_WGT  = 3'd3;
    localparam logic [2:0] S_PROD = 3'd4;
    localparam logic [2:0] S_DIV  = 3'd5;
    localparam logic [2:0] S_ACC  = 3'd6;
    localparam logic [2:0] S_OUT  = 3'd7;

    function automatic logic [16:0] fix_q(input logic [17:0] q, input logic [24:0] n);
        logic [25:0] t;
        t = {q, 8'd0} - {8'd0, q};
        if (t > {1'b0, n}) begin
            return 17'(q - 18'd1);
        end
        return q[16:0];
    endfunction

    function automatic logic [16:0] sat_add(input logic [16:0] acc, input logic [16:0] inc);
        logic [17:0] s;
        s = {1'b0, acc} + {1'b0, inc};
        if (s > 18'(rtc_pkg::Q16_ONE)) begin
            return 17'(rtc_pkg::Q16_ONE);
        end
        return s[16:0];
    endfunction

    function automatic logic [7:0] to_byte(input logic [16:0] acc);
        logic [24:0] t;
        t = {acc, 8'd0} - {8'd0, acc};
        return t[23:16];
    endfunction

    rtc_pkg::t_cfg cfg;

    logic [2:0]  r_state;
    logic [2:0]  n_state;
    logic [31:0] r_diff;
    logic        r_last;
    logic [31:0] r_bin_hi;
    logic [31:0] r_rd_data;
    logic [16:0] r_w;
    logic [24:0] r_prod_r;
    logic [24:0] r_prod_g;
    logic [24:0] r_prod_b;
    logic [17:0] r_q_r;
    logic [17:0] r_q_g;
    logic [17:0] r_q_b;
    logic [16:0] r_acc_r;
    logic [16:0] r_acc_g;
    logic [16:0] r_acc_b;
    logic [16:0] r_acc_a;
    logic        r_pix_valid;
    logic [7:0]  r_pix_r;
    logic [7:0]  r_pix_g;
    logic [7:0]  r_pix_b;
    logic [31:0] r_tbl [BINS];

    logic          in_take;
    logic          out_take;
    logic          is_load;
    logic          in_range;
    logic [31:0]   diff;
    logic          tbl_we;
    logic          tbl_re;
    logic [AW-1:0] tbl_waddr;
    logic [AW-1:0] tbl_raddr;
    logic [63:0]   bin_prod;
    logic [16:0]   op;
    logic [16:0]   inv_a;
    logic [33:0]   w_prod;
    logic [16:0]   n_w;
    logic [40:0]   q_prod_r;
    logic [40:0]   q_prod_g;
    logic [40:0]   q_prod_b;
    logic          pix_free;
    logic          emit;

    rtc_cfg_regs u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (cfg)
    );

    assign i_smp.ready = (r_state == S_IDLE);
    assign in_take     = i_smp.valid && i_smp.ready;
    assign is_load     = (i_smp.cmd == rtc_pkg::CMD_LOAD);
    assign in_range    = ($signed(i_smp.sample_value) >= $signed(cfg.range_min))
                      && ($signed(i_smp.sample_value) <= $signed(cfg.range_max));
    assign diff        = i_smp.sample_value - cfg.range_min;

    assign tbl_we    = in_take && is_load && ({24'd0, i_smp.entry_index} < 32'(BINS));
    assign tbl_waddr = AW'(i_smp.entry_index);
    assign tbl_re    = (r_state == S_RD);
    assign tbl_raddr = (r_bin_hi >= 32'(BINS)) ? AW'(BINS - 1) : r_bin_hi[AW-1:0];

    assign bin_prod = 64'(r_diff) * 64'(cfg.bin_scale);
    assign op       = OP_ROM[r_rd_data[31:24]];
    assign inv_a    = 17'(rtc_pkg::Q16_ONE - {15'd0, r_acc_a});
    assign w_prod   = 34'(inv_a) * 34'(op);
    assign n_w      = w_prod[32:16];
    assign q_prod_r = 41'(r_prod_r) * 41'(rtc_pkg::RECIP_255);
    assign q_prod_g = 41'(r_prod_g) * 41'(rtc_pkg::RECIP_255);
    assign q_prod_b = 41'(r_prod_b) * 41'(rtc_pkg::RECIP_255);

    assign out_take = o_pix.valid && o_pix.ready;
    assign pix_free = !r_pix_valid || o_pix.ready;
    assign emit     = (r_state == S_OUT) && r_last && pix_free;

    assign o_pix.valid       = r_pix_valid;
    assign o_pix.pixel_red   = r_pix_r;
    assign o_pix.pixel_green = r_pix_g;
    assign o_pix.pixel_blue  = r_pix_b;

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (in_take && !is_load) begin
                    n_state = in_range ? S_MUL : S_OUT;
                end
            end
            S_MUL:  n_state = S_RD;
            S_RD:   n_state = S_WGT;
            S_WGT:  n_state = S_PROD;
            S_PROD: n_state = S_DIV;
            S_DIV:  n_state = S_ACC;
            S_ACC:  n_state = S_OUT;
            S_OUT: begin
                if (!r_last || pix_free) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (tbl_we) begin
            r_tbl[tbl_waddr] <= {i_smp.entry_opacity, i_smp.entry_blue,
                                 i_smp.entry_green, i_smp.entry_red};
        end
        if (tbl_re) begin
            r_rd_data <= r_tbl[tbl_raddr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_acc_r     <= 17'd0;
            r_acc_g     <= 17'd0;
            r_acc_b     <= 17'd0;
            r_acc_a     <= 17'd0;
            r_pix_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (r_state == S_ACC) begin
                r_acc_r <= sat_add(r_acc_r, fix_q(r_q_r, r_prod_r));
                r_acc_g <= sat_add(r_acc_g, fix_q(r_q_g, r_prod_g));
                r_acc_b <= sat_add(r_acc_b, fix_q(r_q_b, r_prod_b));
                r_acc_a <= sat_add(r_acc_a, r_w);
            end else if (emit) begin
                r_acc_r <= 17'd0;
                r_acc_g <= 17'd0;
                r_acc_b <= 17'd0;
                r_acc_a <= 17'd0;
            end
            if (emit) begin
                r_pix_valid <= 1'b1;
            end else if (out_take) begin
                r_pix_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_take) begin
            r_diff <= diff;
            r_last <= i_smp.last_sample;
        end
        if (r_state == S_MUL) begin
            r_bin_hi <= bin_prod[63:32];
        end
        if (r_state == S_WGT) begin
            r_w <= n_w;
        end
        if (r_state == S_PROD) begin
            r_prod_r <= 25'(r_w) * 25'(r_rd_data[7:0]);
            r_prod_g <= 25'(r_w) * 25'(r_rd_data[15:8]);
            r_prod_b <= 25'(r_w) * 25'(r_rd_data[23:16]);
        end
        if (r_state == S_DIV) begin
            r_q_r <= q_prod_r[40:23];
            r_q_g <= q_prod_g[40:23];
            r_q_b <= q_prod_b[40:23];
        end
        if (emit) begin
            r_pix_r <= to_byte(r_acc_r);
            r_pix_g <= to_byte(r_acc_g);
            r_pix_b <= to_byte(r_acc_b);
        end
    end

    `RTC_ASSERT_IMP(a_no_rw_overlap, tbl_we, !tbl_re, "table write during a table read")
    `RTC_ASSERT_NXT(a_emit_clears, emit, (r_acc_a == 17'd0) && r_pix_valid, "emit left state")
    `RTC_ASSERT_IMP(a_valid_source, $rose(r_pix_valid), $past(r_state) == S_OUT, "stray pixel")
    `RTC_ASSERT_NXT(a_alpha_bound, r_state == S_ACC, r_acc_a <= 17'd65536, "alpha overflow")

endmodule
